// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the mixer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== rtl/core/mvrm_pkg.sv =====
// Shared types and constants of the resampling mixer.
package mvrm_pkg;
   localparam int DEF_VOICE_COUNT   = 8;
   localparam int DEF_SAMPLE_WORDS  = 65536;
   localparam int DEF_FRACTION_BITS = 16;

   localparam int TYPE_W  = 3;
   localparam int VIDX_W  = 3;
   localparam int BASE_W  = 18;
   localparam int LEN_W   = 19;
   localparam int STEP_W  = 24;
   localparam int GAIN_W  = 16;
   localparam int MADDR_W = 16;
   localparam int MWORD_W = 32;
   localparam int SAMP_W  = 16;
   localparam int MASK_W  = 8;

   localparam int REQ_DATA_W = 152;
   localparam int RSP_DATA_W = 40;

   localparam logic [TYPE_W-1:0] REQ_PLAY   = 3'd0;
   localparam logic [TYPE_W-1:0] REQ_STOP   = 3'd1;
   localparam logic [TYPE_W-1:0] REQ_VOLUME = 3'd2;
   localparam logic [TYPE_W-1:0] REQ_STEP   = 3'd3;
   localparam logic [TYPE_W-1:0] REQ_LOAD   = 3'd4;
   localparam logic [TYPE_W-1:0] REQ_MIX    = 3'd5;

   typedef struct packed {
      logic [TYPE_W-1:0]  kind;
      logic [VIDX_W-1:0]  voice;
      logic [BASE_W-1:0]  base;
      logic [LEN_W-1:0]   len;
      logic               stereo;
      logic               wide;
      logic               loop;
      logic [STEP_W-1:0]  step;
      logic [GAIN_W-1:0]  gain_l;
      logic [GAIN_W-1:0]  gain_r;
      logic [MADDR_W-1:0] maddr;
      logic [MWORD_W-1:0] mword;
   } req_word_type;

   typedef struct packed {
      logic [BASE_W-1:0] base;
      logic [LEN_W-1:0]  len;
      logic              stereo;
      logic              wide;
      logic              loop;
      logic [STEP_W-1:0] step;
      logic [GAIN_W-1:0] gain_l;
      logic [GAIN_W-1:0] gain_r;
   } voice_cfg_type;

   localparam int CFG_W = $bits(voice_cfg_type);

   typedef struct packed {
      logic signed [SAMP_W-1:0] left;
      logic signed [SAMP_W-1:0] right;
      logic                     frame_valid;
      logic [MASK_W-1:0]        mask;
   } mix_result_type;
endpackage

// ===== rtl/core/multi_voice_resampling_mixer_core.sv =====
// Top level of the multi-voice resampling mixer: ports, output register, assertions.
//
// One command word in on req_*, exactly one result word out on rsp_* per command.
// req_tuser carries the command kind; rsp_tuser flags a mixed frame.
// Commands are handled one at a time by a sequencer over the voice table
// memory and the sample memory (both with registered synchronous reads).
// Per command: play, stop, load and unknown kinds finish directly; set volume and
//   set step add a table read-modify-write. A mix visits every voice in turn; for
//   each active voice it reads the table entry, fetches the sample bytes of both
//   frames (none for a silent frame), interpolates, scales and accumulates, then
//   advances the position, wraps it for a looping voice only, and writes it back.
//   Sample bytes are fetched one at a time through the single read port.
// Reset clears the control state and all voices to inactive; sample memory is
// not cleared and must be loaded before it is played.
// A finished result sits in an output register; the next command is taken
// while it waits, and runs until its own result needs that register. While
// rsp_tready is low the result holds and the sequencer waits.
module multi_voice_resampling_mixer_core #(
   parameter int VOICE_COUNT   = mvrm_pkg::DEF_VOICE_COUNT,
   parameter int SAMPLE_WORDS  = mvrm_pkg::DEF_SAMPLE_WORDS,
   parameter int FRACTION_BITS = mvrm_pkg::DEF_FRACTION_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // voice_index, base_addr, frame_count, two_channels, sixteen_bit, loop_flag,
   // step, volume_left, volume_right, mem_word_addr, mem_word, zero pad
   input  logic [mvrm_pkg::REQ_DATA_W-1:0]     req_tdata,
   // req_type
   input  logic [mvrm_pkg::TYPE_W-1:0]         req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // out_left, out_right, playing_mask
   output logic [mvrm_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // frame_valid
   output logic                                rsp_tuser
);
   import mvrm_pkg::*;

   `include "assert_macros.svh"

   localparam int VW    = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
   localparam int ENT_W = CFG_W + LEN_W + FRACTION_BITS;
   localparam int WA    = $clog2(SAMPLE_WORDS);

   req_word_type   req_word;
   mix_result_type res;
   logic           res_valid, res_ready;
   logic           tbl_wr_en, tbl_rd_en;
   logic [VW-1:0]  tbl_wr_addr, tbl_rd_addr;
   logic [ENT_W-1:0] tbl_wr_data, tbl_rd_data;
   logic           smem_wr_en, smem_rd_en;
   logic [WA-1:0]  smem_wr_addr, smem_rd_addr;
   logic [MWORD_W-1:0] smem_wr_data, smem_rd_data;

   logic           rsp_valid_ff, rsp_valid_in;
   mix_result_type rsp_word_ff, rsp_word_in;

   always_comb begin
      req_word.kind   = req_tuser;
      req_word.voice  = req_tdata[2:0];
      req_word.base   = req_tdata[20:3];
      req_word.len    = req_tdata[39:21];
      req_word.stereo = req_tdata[40];
      req_word.wide   = req_tdata[41];
      req_word.loop   = req_tdata[42];
      req_word.step   = req_tdata[66:43];
      req_word.gain_l = req_tdata[82:67];
      req_word.gain_r = req_tdata[98:83];
      req_word.maddr  = req_tdata[114:99];
      req_word.mword  = req_tdata[146:115];
   end

   mvrm_voice_table #(
      .DEPTH (VOICE_COUNT),
      .WIDTH (ENT_W)
   ) u_table (
      .clock   (clock),
      .wr_en   (tbl_wr_en),
      .wr_addr (tbl_wr_addr),
      .wr_data (tbl_wr_data),
      .rd_en   (tbl_rd_en),
      .rd_addr (tbl_rd_addr),
      .rd_data (tbl_rd_data)
   );

   mvrm_sample_mem #(
      .WORDS (SAMPLE_WORDS)
   ) u_smem (
      .clock   (clock),
      .wr_en   (smem_wr_en),
      .wr_addr (smem_wr_addr),
      .wr_data (smem_wr_data),
      .rd_en   (smem_rd_en),
      .rd_addr (smem_rd_addr),
      .rd_data (smem_rd_data)
   );

   mvrm_sequencer #(
      .VOICE_COUNT   (VOICE_COUNT),
      .SAMPLE_WORDS  (SAMPLE_WORDS),
      .FRACTION_BITS (FRACTION_BITS)
   ) u_seq (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (req_tvalid),
      .in_ready     (req_tready),
      .in_word      (req_word),
      .res_valid    (res_valid),
      .res_ready    (res_ready),
      .res          (res),
      .tbl_wr_en    (tbl_wr_en),
      .tbl_wr_addr  (tbl_wr_addr),
      .tbl_wr_data  (tbl_wr_data),
      .tbl_rd_en    (tbl_rd_en),
      .tbl_rd_addr  (tbl_rd_addr),
      .tbl_rd_data  (tbl_rd_data),
      .smem_wr_en   (smem_wr_en),
      .smem_wr_addr (smem_wr_addr),
      .smem_wr_data (smem_wr_data),
      .smem_rd_en   (smem_rd_en),
      .smem_rd_addr (smem_rd_addr),
      .smem_rd_data (smem_rd_data)
   );

   // output word register
   assign res_ready = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_word_in  = rsp_word_ff;
      if (res_valid && res_ready) begin
         rsp_valid_in = 1'b1;
         rsp_word_in  = res;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_word_ff.mask, rsp_word_ff.right, rsp_word_ff.left};
   assign rsp_tuser  = rsp_word_ff.frame_valid;

   `ASSERT_NEXT(a_result_lands, clock, reset, res_valid && res_ready, rsp_tvalid)
   `ASSERT_IMPLIES(a_accept_without_result, clock, reset, req_tvalid && req_tready, !res_valid)
   `ASSERT_IMPLIES(a_nonmix_silent, clock, reset, rsp_tvalid && !rsp_tuser,
                   rsp_tdata[31:0] == 32'd0)
endmodule

// ===== rtl/core/mvrm_voice_table.sv =====
// Voice table memory: one write port, one registered read port.
module mvrm_voice_table #(
   parameter int DEPTH = 8,
   parameter int WIDTH = 131
) (
   input  logic                                 clock,
   input  logic                                 wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                     wr_data,
   input  logic                                 rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                     rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== rtl/core/mvrm_sample_mem.sv =====
// Sample memory: 32-bit words, one write port, one registered read port.
module mvrm_sample_mem #(
   parameter int WORDS = 65536
) (
   input  logic                      clock,
   input  logic                      wr_en,
   input  logic [$clog2(WORDS)-1:0]  wr_addr,
   input  logic [mvrm_pkg::MWORD_W-1:0] wr_data,
   input  logic                      rd_en,
   input  logic [$clog2(WORDS)-1:0]  rd_addr,
   output logic [mvrm_pkg::MWORD_W-1:0] rd_data
);
   import mvrm_pkg::*;

   logic [MWORD_W-1:0] mem_ff [WORDS];
   logic [MWORD_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== rtl/core/mvrm_sequencer.sv =====
// Command sequencer: voice table read-modify-write, sample fetch, interpolation and mixing.
module mvrm_sequencer #(
   parameter int VOICE_COUNT   = mvrm_pkg::DEF_VOICE_COUNT,
   parameter int SAMPLE_WORDS  = mvrm_pkg::DEF_SAMPLE_WORDS,
   parameter int FRACTION_BITS = mvrm_pkg::DEF_FRACTION_BITS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  mvrm_pkg::req_word_type in_word,
   output logic                   res_valid,
   input  logic                   res_ready,
   output mvrm_pkg::mix_result_type res,
   output logic                   tbl_wr_en,
   output logic [(VOICE_COUNT > 1 ? $clog2(VOICE_COUNT) : 1)-1:0] tbl_wr_addr,
   output logic [mvrm_pkg::CFG_W+mvrm_pkg::LEN_W+FRACTION_BITS-1:0] tbl_wr_data,
   output logic                   tbl_rd_en,
   output logic [(VOICE_COUNT > 1 ? $clog2(VOICE_COUNT) : 1)-1:0] tbl_rd_addr,
   input  logic [mvrm_pkg::CFG_W+mvrm_pkg::LEN_W+FRACTION_BITS-1:0] tbl_rd_data,
   output logic                   smem_wr_en,
   output logic [$clog2(SAMPLE_WORDS)-1:0] smem_wr_addr,
   output logic [mvrm_pkg::MWORD_W-1:0] smem_wr_data,
   output logic                   smem_rd_en,
   output logic [$clog2(SAMPLE_WORDS)-1:0] smem_rd_addr,
   input  logic [mvrm_pkg::MWORD_W-1:0] smem_rd_data
);
   import mvrm_pkg::*;

   localparam int VW         = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
   localparam int F          = FRACTION_BITS;
   localparam int POS_W      = LEN_W + F;
   localparam int ENT_W      = CFG_W + POS_W;
   localparam int WA         = $clog2(SAMPLE_WORDS);
   localparam int AB         = WA + 2;
   localparam int IDX_W      = LEN_W + 1;
   localparam int ASUM_W     = IDX_W + 3;
   localparam int WRAP_STEPS = STEP_W - F + 1;
   localparam int KW         = (WRAP_STEPS > 1) ? $clog2(WRAP_STEPS) : 1;
   localparam int REM_W      = POS_W + WRAP_STEPS;
   localparam int MA_W       = 18;
   localparam int MB_W       = (F + 2 > 17) ? F + 2 : 17;
   localparam int PROD_W     = MA_W + MB_W;
   localparam int LSUM_W     = PROD_W + 1;
   localparam int ACC_W      = 20;

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_EXEC     = 4'd1;
   localparam logic [3:0] S_RMW      = 4'd2;
   localparam logic [3:0] S_VOICE    = 4'd3;
   localparam logic [3:0] S_ENTRY    = 4'd4;
   localparam logic [3:0] S_FSETUP   = 4'd5;
   localparam logic [3:0] S_RD_ISSUE = 4'd6;
   localparam logic [3:0] S_RD_CAP   = 4'd7;
   localparam logic [3:0] S_MUL      = 4'd8;
   localparam logic [3:0] S_ACC      = 4'd9;
   localparam logic [3:0] S_ADV      = 4'd10;
   localparam logic [3:0] S_WRAP     = 4'd11;
   localparam logic [3:0] S_WB       = 4'd12;
   localparam logic [3:0] S_DONE     = 4'd13;

   function automatic logic signed [16:0] narrow_smp(input logic [7:0] b);
      return $signed({1'b0, b, 8'h00}) - 17'sd32767;
   endfunction

   function automatic logic signed [16:0] wide_smp(input logic [7:0] hi, input logic [7:0] lo);
      return $signed({hi[7], hi, lo});
   endfunction

   // control
   logic [3:0]       state_ff, state_in;
   logic [VOICE_COUNT-1:0] active_ff, active_in;
   logic [VOICE_COUNT-1:0] playing_ff, playing_in;
   // payload
   req_word_type     cmd_ff, cmd_in;
   logic [VW-1:0]    vcnt_ff, vcnt_in;
   voice_cfg_type    cfg_ff, cfg_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic             sel_ff, sel_in;
   logic [1:0]       byte_ff, byte_in;
   logic [1:0][3:0][7:0] bytes_ff, bytes_in;
   logic [1:0]       silent_ff, silent_in;
   logic [AB-1:0]    faddr_ff, faddr_in;
   logic [2:0]       mstep_ff, mstep_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [LSUM_W-1:0] lsum_ff, lsum_in;
   logic signed [16:0] interp_ff, interp_in;
   logic signed [SAMP_W-1:0] accl_ff, accl_in, accr_ff, accr_in;
   logic             fv_ff, fv_in;
   logic [REM_W-1:0] rem_ff, rem_in;
   logic [KW-1:0]    k_ff, k_in;

   // combinational helpers
   logic [VW+VIDX_W-1:0] voice_ext;
   logic [VW-1:0]    cmd_vaddr;
   logic             cmd_vok;
   logic [WA+MADDR_W-1:0] load_ext;
   logic             last_voice;
   logic [IDX_W-1:0] idx_raw, idx_eff, len_ext;
   logic             idx_past, wrap_ok, fr_silent;
   logic [1:0]       bpf_sh, last_byte;
   logic [ASUM_W-1:0] faddr_sum;
   logic [AB-1:0]    baddr;
   logic [7:0]       lane_byte;
   logic signed [16:0] a_l, a_r, b_l, b_r;
   logic [F-1:0]     frac;
   logic [F:0]       wone;
   logic signed [MA_W-1:0] op_a;
   logic signed [MB_W-1:0] op_b;
   logic signed [LSUM_W-1:0] lsum_t, lsum_adj;
   logic signed [PROD_W-1:0] prod_adj, prod_sh;
   logic signed [ACC_W-1:0] gain_x, acc_sel, acc_sum;
   logic signed [SAMP_W-1:0] acc_sat;
   logic [POS_W:0]   psum;
   logic [REM_W-1:0] modk, rem_nx;
   voice_cfg_type    cfg_new, cfg_mod;
   logic [VOICE_COUNT+MASK_W-1:0] mask_ext;

   assign voice_ext = {{VW{1'b0}}, cmd_ff.voice};
   assign cmd_vaddr = voice_ext[VW-1:0];
   assign cmd_vok   = ({3'b000, cmd_ff.voice} < 6'(VOICE_COUNT));
   assign load_ext  = {{WA{1'b0}}, cmd_ff.maddr};
   assign last_voice = (vcnt_ff == VW'(VOICE_COUNT - 1));

   // frame index and byte address of the frame being set up
   assign wrap_ok  = cfg_ff.loop && (cfg_ff.len != '0);
   assign idx_raw  = {1'b0, pos_ff[POS_W-1:F]} + {{(IDX_W-1){1'b0}}, sel_ff};
   assign len_ext  = {1'b0, cfg_ff.len};
   assign idx_past = (idx_raw >= len_ext);
   assign fr_silent = idx_past && !wrap_ok;
   // position stays below the loop length, so one step past the end wraps to frame 0
   assign idx_eff  = idx_past ? '0 : idx_raw;
   always_comb begin
      unique case ({cfg_ff.stereo, cfg_ff.wide})
         2'b00:   begin bpf_sh = 2'd0; last_byte = 2'd0; end
         2'b01:   begin bpf_sh = 2'd1; last_byte = 2'd1; end
         2'b10:   begin bpf_sh = 2'd1; last_byte = 2'd1; end
         default: begin bpf_sh = 2'd2; last_byte = 2'd3; end
      endcase
   end
   assign faddr_sum = ASUM_W'(cfg_ff.base) + (ASUM_W'(idx_eff) << bpf_sh);
   assign baddr = faddr_ff + AB'(byte_ff);

   always_comb begin
      unique case (baddr[1:0])
         2'd0:    lane_byte = smem_rd_data[7:0];
         2'd1:    lane_byte = smem_rd_data[15:8];
         2'd2:    lane_byte = smem_rd_data[23:16];
         default: lane_byte = smem_rd_data[31:24];
      endcase
   end

   // sample decode for both frames
   always_comb begin
      if (silent_ff[0]) begin
         a_l = '0;
         a_r = '0;
      end else if (cfg_ff.wide) begin
         a_l = wide_smp(bytes_ff[0][1], bytes_ff[0][0]);
         a_r = cfg_ff.stereo ? wide_smp(bytes_ff[0][3], bytes_ff[0][2]) : a_l;
      end else begin
         a_l = narrow_smp(bytes_ff[0][0]);
         a_r = cfg_ff.stereo ? narrow_smp(bytes_ff[0][1]) : a_l;
      end
      if (silent_ff[1]) begin
         b_l = '0;
         b_r = '0;
      end else if (cfg_ff.wide) begin
         b_l = wide_smp(bytes_ff[1][1], bytes_ff[1][0]);
         b_r = cfg_ff.stereo ? wide_smp(bytes_ff[1][3], bytes_ff[1][2]) : b_l;
      end else begin
         b_l = narrow_smp(bytes_ff[1][0]);
         b_r = cfg_ff.stereo ? narrow_smp(bytes_ff[1][1]) : b_l;
      end
   end

   // shared multiplier operands
   assign frac = pos_ff[F-1:0];
   assign wone = (F+1)'(1 << F) - {1'b0, frac};
   always_comb begin
      unique case (mstep_ff)
         3'd0:    begin op_a = MA_W'(a_l); op_b = $signed(MB_W'(wone)); end
         3'd1:    begin op_a = MA_W'(b_l); op_b = $signed(MB_W'(frac)); end
         3'd2:    begin op_a = MA_W'(interp_ff); op_b = $signed(MB_W'(cfg_ff.gain_l)); end
         3'd3:    begin op_a = MA_W'(a_r); op_b = $signed(MB_W'(wone)); end
         3'd4:    begin op_a = MA_W'(b_r); op_b = $signed(MB_W'(frac)); end
         default: begin op_a = MA_W'(interp_ff); op_b = $signed(MB_W'(cfg_ff.gain_r)); end
      endcase
   end

   // truncating divides toward zero
   assign lsum_t   = lsum_ff + LSUM_W'(prod_ff);
   assign lsum_adj = lsum_t + $signed({{(LSUM_W-F){1'b0}}, {F{lsum_t[LSUM_W-1]}}});
   assign prod_adj = prod_ff + $signed({{(PROD_W-14){1'b0}}, {14{prod_ff[PROD_W-1]}}});
   assign prod_sh  = prod_adj >>> 14;
   assign gain_x   = prod_sh[ACC_W-1:0];
   assign acc_sel  = ACC_W'((mstep_ff == 3'd2) ? accl_ff : accr_ff);
   assign acc_sum  = acc_sel + gain_x;
   always_comb begin
      if (acc_sum > 20'sd32767) begin
         acc_sat = 16'sh7FFF;
      end else if (acc_sum < -20'sd32768) begin
         acc_sat = 16'sh8000;
      end else begin
         acc_sat = acc_sum[SAMP_W-1:0];
      end
   end

   assign psum   = {1'b0, pos_ff} + (POS_W+1)'(cfg_ff.step);
   assign modk   = REM_W'({cfg_ff.len, {F{1'b0}}}) << k_ff;
   assign rem_nx = (rem_ff >= modk) ? (rem_ff - modk) : rem_ff;

   always_comb begin
      cfg_new.base   = cmd_ff.base;
      cfg_new.len    = cmd_ff.len;
      cfg_new.stereo = cmd_ff.stereo;
      cfg_new.wide   = cmd_ff.wide;
      cfg_new.loop   = cmd_ff.loop;
      cfg_new.step   = cmd_ff.step;
      cfg_new.gain_l = cmd_ff.gain_l;
      cfg_new.gain_r = cmd_ff.gain_r;
      cfg_mod = tbl_rd_data[CFG_W-1:0];
      if (cmd_ff.kind == REQ_VOLUME) begin
         cfg_mod.gain_l = cmd_ff.gain_l;
         cfg_mod.gain_r = cmd_ff.gain_r;
      end else begin
         cfg_mod.step = cmd_ff.step;
      end
   end

   always_comb begin
      state_in   = state_ff;
      active_in  = active_ff;
      playing_in = playing_ff;
      cmd_in     = cmd_ff;
      vcnt_in    = vcnt_ff;
      cfg_in     = cfg_ff;
      pos_in     = pos_ff;
      sel_in     = sel_ff;
      byte_in    = byte_ff;
      bytes_in   = bytes_ff;
      silent_in  = silent_ff;
      faddr_in   = faddr_ff;
      mstep_in   = mstep_ff;
      prod_in    = prod_ff;
      lsum_in    = lsum_ff;
      interp_in  = interp_ff;
      accl_in    = accl_ff;
      accr_in    = accr_ff;
      fv_in      = fv_ff;
      rem_in     = rem_ff;
      k_in       = k_ff;
      in_ready   = 1'b0;
      res_valid  = 1'b0;
      tbl_wr_en  = 1'b0;
      tbl_wr_addr = cmd_vaddr;
      tbl_wr_data = {POS_W'(0), cfg_new};
      tbl_rd_en  = 1'b0;
      tbl_rd_addr = cmd_vaddr;
      smem_wr_en = 1'b0;
      smem_wr_addr = load_ext[WA-1:0];
      smem_wr_data = cmd_ff.mword;
      smem_rd_en = 1'b0;
      smem_rd_addr = baddr[AB-1:2];

      unique case (state_ff)
         S_IDLE: begin
            in_ready = 1'b1;
            if (in_valid) begin
               cmd_in   = in_word;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            fv_in    = (cmd_ff.kind == REQ_MIX);
            state_in = S_DONE;
            unique case (cmd_ff.kind)
               REQ_PLAY: begin
                  if (cmd_vok) begin
                     tbl_wr_en = 1'b1;
                     active_in[cmd_vaddr]  = 1'b1;
                     playing_in[cmd_vaddr] = (cmd_ff.len != '0);
                  end
               end
               REQ_STOP: begin
                  if (cmd_vok) begin
                     active_in[cmd_vaddr]  = 1'b0;
                     playing_in[cmd_vaddr] = 1'b0;
                  end
               end
               REQ_VOLUME, REQ_STEP: begin
                  if (cmd_vok) begin
                     tbl_rd_en = 1'b1;
                     state_in  = S_RMW;
                  end
               end
               REQ_LOAD: begin
                  smem_wr_en = 1'b1;
               end
               REQ_MIX: begin
                  accl_in  = '0;
                  accr_in  = '0;
                  vcnt_in  = '0;
                  state_in = S_VOICE;
               end
               default: begin
                  state_in = S_DONE;
               end
            endcase
         end
         S_RMW: begin
            tbl_wr_en   = 1'b1;
            tbl_wr_data = {tbl_rd_data[ENT_W-1:CFG_W], cfg_mod};
            state_in    = S_DONE;
         end
         S_VOICE: begin
            if (active_ff[vcnt_ff]) begin
               tbl_rd_en   = 1'b1;
               tbl_rd_addr = vcnt_ff;
               state_in    = S_ENTRY;
            end else if (last_voice) begin
               state_in = S_DONE;
            end else begin
               vcnt_in = vcnt_ff + 1'b1;
            end
         end
         S_ENTRY: begin
            cfg_in   = tbl_rd_data[CFG_W-1:0];
            pos_in   = tbl_rd_data[ENT_W-1:CFG_W];
            sel_in   = 1'b0;
            state_in = S_FSETUP;
         end
         S_FSETUP: begin
            silent_in[sel_ff] = fr_silent;
            if (fr_silent) begin
               if (sel_ff) begin
                  mstep_in = '0;
                  state_in = S_MUL;
               end else begin
                  sel_in = 1'b1;
               end
            end else begin
               faddr_in = faddr_sum[AB-1:0];
               byte_in  = '0;
               state_in = S_RD_ISSUE;
            end
         end
         S_RD_ISSUE: begin
            smem_rd_en = 1'b1;
            state_in   = S_RD_CAP;
         end
         S_RD_CAP: begin
            bytes_in[sel_ff][byte_ff] = lane_byte;
            if (byte_ff == last_byte) begin
               if (sel_ff) begin
                  mstep_in = '0;
                  state_in = S_MUL;
               end else begin
                  sel_in   = 1'b1;
                  state_in = S_FSETUP;
               end
            end else begin
               byte_in  = byte_ff + 1'b1;
               state_in = S_RD_ISSUE;
            end
         end
         S_MUL: begin
            prod_in  = op_a * op_b;
            state_in = S_ACC;
         end
         S_ACC: begin
            unique case (mstep_ff)
               3'd0, 3'd3: lsum_in = LSUM_W'(prod_ff);
               3'd1, 3'd4: begin
                  lsum_in   = lsum_t;
                  interp_in = 17'(lsum_adj >>> F);
               end
               3'd2: accl_in = acc_sat;
               default: accr_in = acc_sat;
            endcase
            if (mstep_ff == 3'd5) begin
               state_in = S_ADV;
            end else begin
               mstep_in = mstep_ff + 1'b1;
               state_in = S_MUL;
            end
         end
         S_ADV: begin
            if (wrap_ok) begin
               rem_in   = REM_W'(psum);
               k_in     = KW'(WRAP_STEPS - 1);
               state_in = S_WRAP;
            end else begin
               pos_in   = psum[POS_W] ? {POS_W{1'b1}} : psum[POS_W-1:0];
               state_in = S_WB;
            end
         end
         S_WRAP: begin
            // one compare-subtract of the shifted loop length per cycle
            rem_in = rem_nx;
            if (k_ff == '0) begin
               pos_in   = rem_nx[POS_W-1:0];
               state_in = S_WB;
            end else begin
               k_in = k_ff - 1'b1;
            end
         end
         S_WB: begin
            tbl_wr_en   = 1'b1;
            tbl_wr_addr = vcnt_ff;
            tbl_wr_data = {pos_ff, cfg_ff};
            playing_in[vcnt_ff] = (pos_ff[POS_W-1:F] < cfg_ff.len);
            if (last_voice) begin
               state_in = S_DONE;
            end else begin
               vcnt_in  = vcnt_ff + 1'b1;
               state_in = S_VOICE;
            end
         end
         S_DONE: begin
            res_valid = 1'b1;
            if (res_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         active_ff  <= '0;
         playing_ff <= '0;
      end else begin
         state_ff   <= state_in;
         active_ff  <= active_in;
         playing_ff <= playing_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff    <= cmd_in;
      vcnt_ff   <= vcnt_in;
      cfg_ff    <= cfg_in;
      pos_ff    <= pos_in;
      sel_ff    <= sel_in;
      byte_ff   <= byte_in;
      bytes_ff  <= bytes_in;
      silent_ff <= silent_in;
      faddr_ff  <= faddr_in;
      mstep_ff  <= mstep_in;
      prod_ff   <= prod_in;
      lsum_ff   <= lsum_in;
      interp_ff <= interp_in;
      accl_ff   <= accl_in;
      accr_ff   <= accr_in;
      fv_ff     <= fv_in;
      rem_ff    <= rem_in;
      k_ff      <= k_in;
   end

   assign mask_ext        = {{MASK_W{1'b0}}, playing_ff};
   assign res.left        = fv_ff ? accl_ff : '0;
   assign res.right       = fv_ff ? accr_ff : '0;
   assign res.frame_valid = fv_ff;
   assign res.mask        = mask_ext[MASK_W-1:0];
endmodule

// ===== sim/multi_voice_resampling_mixer_core_check.sv =====
// Watches both channels of the mixer, predicts each result word and compares.
module multi_voice_resampling_mixer_core_check (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   input  logic                            req_tready,
   input  logic [mvrm_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic [mvrm_pkg::TYPE_W-1:0]     req_tuser,
   input  logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   input  logic [mvrm_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic                            rsp_tuser,
   output int                              errors,
   output int                              pending,
   output int                              frames_out
);
   import mvrm_pkg::*;

   localparam int FB = DEF_FRACTION_BITS;
   localparam logic [63:0] POS_LIMIT = (64'd1 << (19 + FB)) - 64'd1;

   logic [31:0]       sample_mem [DEF_SAMPLE_WORDS];
   logic              v_on     [8];
   logic              v_loop   [8];
   logic              v_stereo [8];
   logic              v_wide   [8];
   logic [BASE_W-1:0] v_base   [8];
   logic [LEN_W-1:0]  v_len    [8];
   logic [63:0]       v_pos    [8];
   logic [STEP_W-1:0] v_step   [8];
   logic [GAIN_W-1:0] v_gain_l [8];
   logic [GAIN_W-1:0] v_gain_r [8];

   mix_result_type expected_frames[$];

   function automatic int mem_byte(longint unsigned a);
      longint unsigned b;
      logic [31:0] w;
      b = a % (longint'(DEF_SAMPLE_WORDS) * 4);
      w = sample_mem[b >> 2];
      return int'((w >> ((b & 3) * 8)) & 32'hFF);
   endfunction

   function automatic int sample_at(longint unsigned a, logic wide);
      logic [15:0] u;
      if (wide) begin
         u = 16'(mem_byte(a) | (mem_byte(a + 1) << 8));
         return int'($signed(u));
      end
      return mem_byte(a) * 256 - 32767;
   endfunction

   function automatic void fetch_frame(int v, longint unsigned idx, output int l, output int r);
      longint unsigned len, ssize, addr;
      len = v_len[v];
      ssize = v_wide[v] ? 2 : 1;
      if (v_loop[v] && len != 0 && idx >= len) idx = idx % len;
      if (idx >= len) begin
         l = 0;
         r = 0;
         return;
      end
      addr = longint'(v_base[v]) + idx * ssize * (v_stereo[v] ? 2 : 1);
      l = sample_at(addr, v_wide[v]);
      r = v_stereo[v] ? sample_at(addr + ssize, v_wide[v]) : l;
   endfunction

   function automatic int interp(int a, int b, longint f);
      longint one;
      one = longint'(1) << FB;
      return int'((longint'(a) * (one - f) + longint'(b) * f) / one);
   endfunction

   function automatic int sat16(int acc, int x);
      int s;
      s = acc + x;
      if (s > 32767) return 32767;
      if (s < -32768) return -32768;
      return s;
   endfunction

   function automatic mix_result_type apply_word(logic [TYPE_W-1:0] k, logic [REQ_DATA_W-1:0] d);
      mix_result_type r;
      int v, l0, r0, l1, r1, sl, sr, acc_l, acc_r;
      longint f;
      logic [63:0] p;
      v = int'(d[2:0]);
      acc_l = 0;
      acc_r = 0;
      r = '0;
      case (k)
         REQ_PLAY: begin
            v_on[v] = 1'b1;
            v_base[v] = d[20:3];
            v_len[v] = d[39:21];
            v_stereo[v] = d[40];
            v_wide[v] = d[41];
            v_loop[v] = d[42];
            v_step[v] = d[66:43];
            v_gain_l[v] = d[82:67];
            v_gain_r[v] = d[98:83];
            v_pos[v] = '0;
         end
         REQ_STOP: v_on[v] = 1'b0;
         REQ_VOLUME: begin
            v_gain_l[v] = d[82:67];
            v_gain_r[v] = d[98:83];
         end
         REQ_STEP: v_step[v] = d[66:43];
         REQ_LOAD: sample_mem[d[114:99]] = d[146:115];
         REQ_MIX: begin
            r.frame_valid = 1'b1;
            for (int i = 0; i < 8; i++) begin
               if (!v_on[i]) continue;
               f = longint'(v_pos[i][FB-1:0]);
               fetch_frame(i, v_pos[i] >> FB, l0, r0);
               fetch_frame(i, (v_pos[i] >> FB) + 1, l1, r1);
               sl = interp(l0, l1, f);
               sr = interp(r0, r1, f);
               sl = int'((longint'(sl) * longint'(v_gain_l[i])) / 16384);
               sr = int'((longint'(sr) * longint'(v_gain_r[i])) / 16384);
               acc_l = sat16(acc_l, sl);
               acc_r = sat16(acc_r, sr);
               p = v_pos[i] + 64'(v_step[i]);
               if (v_loop[i] && v_len[i] != 0) p = p % (64'(v_len[i]) << FB);
               else if (p > POS_LIMIT) p = POS_LIMIT;
               v_pos[i] = p;
            end
         end
         default: ;
      endcase
      r.left = acc_l[15:0];
      r.right = acc_r[15:0];
      for (int i = 0; i < 8; i++)
         r.mask[i] = v_on[i] && ((v_pos[i] >> FB) < 64'(v_len[i]));
      return r;
   endfunction

   always @(posedge clock) begin
      mix_result_type want, got;
      if (reset) begin
         for (int i = 0; i < 8; i++) begin
            v_on[i] = 0; v_loop[i] = 0; v_stereo[i] = 0; v_wide[i] = 0;
            v_base[i] = '0; v_len[i] = '0; v_pos[i] = '0; v_step[i] = '0;
            v_gain_l[i] = '0; v_gain_r[i] = '0;
         end
         expected_frames.delete();
         errors <= 0;
         pending <= 0;
         frames_out <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.left = rsp_tdata[15:0];
            got.right = rsp_tdata[31:16];
            got.mask = rsp_tdata[39:32];
            got.frame_valid = rsp_tuser;
            frames_out <= frames_out + 1;
            if (expected_frames.size() == 0) begin
               $display("%0t unexpected word: got %h", $time, got);
               errors <= errors + 1;
            end else begin
               want = expected_frames.pop_front();
               if (want !== got) begin
                  $display("%0t mismatch: expected L %0d R %0d fv %0b mask %h,",
                           $time, want.left, want.right, want.frame_valid, want.mask,
                           " got L %0d R %0d fv %0b mask %h",
                           got.left, got.right, got.frame_valid, got.mask);
                  errors <= errors + 1;
               end
            end
         end
         if (req_tvalid && req_tready)
            expected_frames.push_back(apply_word(req_tuser, req_tdata));
         pending <= expected_frames.size();
      end
   end
endmodule

// ===== sim/multi_voice_resampling_mixer_core_test.sv =====
// Stimulus and verdict for the multi-voice resampling mixer.
module multi_voice_resampling_mixer_core_test;
   import mvrm_pkg::*;

   localparam logic [TYPE_W-1:0] REQ_SPARE_A = 3'd6;
   localparam logic [TYPE_W-1:0] REQ_SPARE_B = 3'd7;
   localparam int CYCLE_LIMIT = 2000000;

   logic                  clock = 0;
   logic                  reset = 1;
   logic                  req_tvalid = 0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [TYPE_W-1:0]     req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;
   int                    errors, pending, frames_out;
   int                    cycles = 0;
   int                    stall_left = 0;
   bit                    long_hold_done = 0;
   bit                    no_gaps = 0;
   bit                    big_len [8];

   always #1 clock = ~clock;

   multi_voice_resampling_mixer_core dut (
      .clock, .reset, .req_tvalid, .req_tready, .req_tdata, .req_tuser,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tuser
   );

   multi_voice_resampling_mixer_core_check checker_i (
      .clock, .reset, .req_tvalid, .req_tready, .req_tdata, .req_tuser,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tuser,
      .errors, .pending, .frames_out
   );

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("multi_voice_resampling_mixer_core test failed");
         $finish;
      end
   end

   // receiver: short random stalls, one long hold-off once traffic is flowing
   always @(posedge clock) begin
      int n;
      bit rdy;
      n = stall_left;
      if (!long_hold_done && frames_out >= 120) begin
         long_hold_done <= 1;
         n = 400;
      end
      if (n > 0) begin
         rdy = 0;
         n--;
      end else begin
         rdy = 1;
         if ($urandom_range(0, 9) == 0) begin
            rdy = 0;
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 3);
         end
      end
      stall_left <= n;
      rsp_tready <= reset ? 1'b0 : rdy;
   end

   function automatic logic [REQ_DATA_W-1:0] pack_word(
      logic [2:0] vi, logic [17:0] b, logic [18:0] n, logic st, logic wd, logic lp,
      logic [23:0] stp, logic [15:0] gl, logic [15:0] gr, logic [15:0] ma, logic [31:0] mw);
      return {5'b0, mw, ma, gr, gl, stp, lp, wd, st, n, b, vi};
   endfunction

   function automatic logic [REQ_DATA_W-1:0] noise_word();
      return {5'b0, 32'($urandom), 32'($urandom), 32'($urandom), 32'($urandom), 19'($urandom)};
   endfunction

   task automatic send(logic [TYPE_W-1:0] k, logic [REQ_DATA_W-1:0] d);
      int n;
      req_tdata <= d;
      req_tuser <= k;
      req_tvalid <= 1;
      do @(posedge clock); while (!req_tready);
      n = 0;
      if (!no_gaps && $urandom_range(0, 9) >= 6)
         n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 3);
      if (n > 0) begin
         req_tvalid <= 0;
         repeat (n) @(posedge clock);
      end
   endtask

   task automatic load_word(logic [15:0] a, logic [31:0] w);
      logic [REQ_DATA_W-1:0] d;
      d = noise_word();
      d[114:99] = a;
      d[146:115] = w;
      send(REQ_LOAD, d);
   endtask

   // Voices only ever read bytes 0..255 or the last 16 bytes of memory, all preloaded.
   task automatic play_voice(logic [2:0] v, logic st, logic wd, logic lp, int form,
                             logic [15:0] gl, logic [15:0] gr);
      int bpf, span;
      logic [17:0] b;
      logic [18:0] n;
      logic [23:0] stp;
      bpf = (st ? 2 : 1) * (wd ? 2 : 1);
      big_len[v] = 0;
      if (form == 2) begin
         // long wave held at frame zero
         b = 18'($urandom_range(0, 248));
         n = ($urandom_range(0, 3) == 0) ? 19'd262144 : 19'($urandom_range(1, 262144));
         stp = '0;
         big_len[v] = 1;
      end else begin
         if ($urandom_range(0, 4) == 0) begin
            b = 18'($urandom_range(262128, 262143));
            span = 262144 - int'(b) + 256;
         end else begin
            b = 18'($urandom_range(0, 255));
            span = 256 - int'(b);
         end
         if (form == 1 || span / bpf == 0) n = '0;
         else n = 19'($urandom_range(1, span / bpf));
         stp = ($urandom_range(0, 2) == 0) ? 24'($urandom) : 24'($urandom_range(0, 24'h30000));
      end
      send(REQ_PLAY, pack_word(v, b, n, st, wd, lp, stp, gl, gr, 16'($urandom), $urandom));
   endtask

   task automatic wait_idle();
      req_tvalid <= 0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   initial begin
      int pick;
      logic [2:0] v;
      logic [REQ_DATA_W-1:0] d;
      repeat (12) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      for (int i = 0; i < 64; i++) load_word(16'(i), $urandom);
      for (int i = 65532; i < 65536; i++) load_word(16'(i), $urandom);

      // directed: each format, extremes, restarts, stops, unknown kinds
      send(REQ_MIX, noise_word());
      play_voice(0, 0, 0, 1, 0, 16'h4000, 16'h4000);
      play_voice(1, 1, 1, 0, 0, 16'hFFFF, 16'hFFFF);
      play_voice(2, 1, 0, 1, 0, 16'hFFFF, 16'h0000);
      play_voice(3, 0, 1, 1, 1, 16'h2000, 16'hFFFF);
      play_voice(4, 1, 1, 1, 2, 16'hFFFF, 16'hFFFF);
      play_voice(5, 0, 1, 0, 0, 16'hFFFF, 16'hFFFF);
      play_voice(6, 1, 1, 1, 0, 16'hFFFF, 16'hFFFF);
      play_voice(7, 0, 0, 0, 0, 16'hFFFF, 16'h8000);
      send(REQ_MIX, noise_word());
      send(REQ_MIX, noise_word());
      d = noise_word(); d[2:0] = 3'd0; d[66:43] = 24'hFFFFFF;
      send(REQ_STEP, d);
      d = noise_word(); d[2:0] = 3'd7; d[66:43] = 24'hFFFFFF;
      send(REQ_STEP, d);
      send(REQ_MIX, noise_word());
      send(REQ_MIX, noise_word());
      d = noise_word(); d[2:0] = 3'd1; d[98:67] = 32'h0000FFFF;
      send(REQ_VOLUME, d);
      send(REQ_SPARE_A, noise_word());
      send(REQ_SPARE_B, noise_word());
      d = noise_word(); d[2:0] = 3'd2;
      send(REQ_STOP, d);
      play_voice(1, 0, 0, 1, 0, 16'h4000, 16'h7FFF);
      send(REQ_MIX, noise_word());
      load_word(16'hFFFF, 32'hFFFF_FFFF);
      send(REQ_MIX, noise_word());

      for (int item = 0; item < 310; item++) begin
         no_gaps = (item % 100) >= 70;
         if (item == 155) wait_idle();
         v = 3'($urandom);
         pick = $urandom_range(0, 99);
         if (pick < 35) send(REQ_MIX, noise_word());
         else if (pick < 52)
            play_voice(v, 1'($urandom), 1'($urandom), 1'($urandom),
                       ($urandom_range(0, 9) == 0) ? 2 : (($urandom_range(0, 9) == 0) ? 1 : 0),
                       16'($urandom), 16'($urandom));
         else if (pick < 58) begin
            d = noise_word(); d[2:0] = v;
            send(REQ_STOP, d);
         end else if (pick < 68) begin
            d = noise_word(); d[2:0] = v;
            send(REQ_VOLUME, d);
         end else if (pick < 78) begin
            d = noise_word(); d[2:0] = v;
            if (big_len[v]) d[66:43] = '0;
            else if ($urandom_range(0, 1)) d[66:43] = 24'($urandom_range(0, 24'h30000));
            send(REQ_STEP, d);
         end else if (pick < 96)
            load_word($urandom_range(0, 1) ? 16'($urandom_range(0, 63))
                                           : 16'($urandom_range(65532, 65535)), $urandom);
         else send($urandom_range(0, 1) ? REQ_SPARE_A : REQ_SPARE_B, noise_word());
      end

      wait_idle();
      repeat (400) @(posedge clock);
      if (errors == 0 && pending == 0)
         $display("multi_voice_resampling_mixer_core test passed");
      else
         $display("multi_voice_resampling_mixer_core test failed");
      $finish;
   end
endmodule
